// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker module, clocked on clk and
// disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PPTG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pptg assertion failed");

// next-cycle implication
`define PPTG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pptg assertion failed");

`endif

// File: src/pptg_pkg.sv
// ----------------------------------------------------------------------------
// pptg_pkg
// shared widths, reset values, register indexes and status codes of the
// pedal plausibility torque guard
// ----------------------------------------------------------------------------
`default_nettype none

package pptg_pkg;

  // widths
  localparam int SAMPLE_BITS = 12;
  localparam int HOLD_BITS   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int TORQUE_W    = 11;
  localparam int STATUS_W    = 3;

  // default torque ceiling
  localparam int TORQUE_MAX_DEF = 1400;

  // register reset values
  localparam logic [SAMPLE_BITS-1:0] BRAKE_ACTIVE_RST    = 12'd800;
  localparam logic [SAMPLE_BITS-1:0] THROTTLE_ACTIVE_RST = 12'd800;
  localparam logic [SAMPLE_BITS-1:0] RELEASE_RST         = 12'd200;
  localparam logic [SAMPLE_BITS-1:0] DIFF_LIMIT_RST      = 12'd2000;
  localparam logic [SAMPLE_BITS-1:0] DISCONNECT_RST      = 12'd4050;
  localparam logic [SAMPLE_BITS-1:0] UPPER_VALID_RST     = 12'd4000;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RST      = 12'd3800;
  localparam logic [HOLD_BITS-1:0]   READY_HOLD_RST      = 16'd2000;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRAKE_ACTIVE    = 3'd0,
    REG_THROTTLE_ACTIVE = 3'd1,
    REG_RELEASE         = 3'd2,
    REG_DIFF_LIMIT      = 3'd3,
    REG_DISCONNECT      = 3'd4,
    REG_UPPER_VALID     = 3'd5,
    REG_FULL_SCALE      = 3'd6,
    REG_READY_HOLD      = 3'd7
  } cfg_index_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEL          = 3'd0,
    STAT_DISCONNECT     = 3'd1,
    STAT_DISAGREE       = 3'd2,
    STAT_RANGE          = 3'd3,
    STAT_BRAKE_THROTTLE = 3'd4,
    STAT_BRAKING        = 3'd5,
    STAT_WAITING        = 3'd6
  } status_t;

endpackage

`default_nettype wire

// File: src/pptg_scale.sv
// ----------------------------------------------------------------------------
// pptg_scale
// torque scaling unit: one multiply by the torque ceiling, an overflow
// check, then a restoring divide by the full scale, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pptg_scale #(
  parameter int TorqueMax = pptg_pkg::TORQUE_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [pptg_pkg::SAMPLE_BITS-1:0] avg,
  input  wire logic [pptg_pkg::SAMPLE_BITS-1:0] full_scale,
  output logic                                  done,
  output logic [pptg_pkg::TORQUE_W-1:0]         torque
);

  localparam int TW = $clog2(TorqueMax + 1);
  localparam int PW = pptg_pkg::SAMPLE_BITS + TW;
  localparam int CW = (TW > 1) ? $clog2(TW) : 1;
  localparam int OW = pptg_pkg::TORQUE_W;

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL  = 4'b0010,
    P_CHK  = 4'b0100,
    P_DIV  = 4'b1000
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic                             done_r, done_nxt;
  logic [pptg_pkg::SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [pptg_pkg::SAMPLE_BITS-1:0] fs_r, fs_nxt;
  logic [PW-1:0]                    rem_r, rem_nxt;
  logic [PW-1:0]                    dvs_r, dvs_nxt;
  logic [TW-1:0]                    q_r, q_nxt;
  logic [TW-1:0]                    res_r, res_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             ge;
  logic [TW-1:0]                    q_step;
  logic [OW+TW-1:0]                 res_ext;

  // one subtract and compare step of the divider
  assign ge     = (rem_r >= dvs_r);
  assign q_step = (q_r << 1) | TW'(ge);

  // sequencer and datapath next values
  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    avg_nxt   = avg_r;
    fs_nxt    = fs_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          avg_nxt   = avg;
          // a full scale of zero acts as one
          fs_nxt    = (full_scale == '0) ? pptg_pkg::SAMPLE_BITS'(1) : full_scale;
          phase_nxt = P_MUL;
        end
      end
      P_MUL: begin
        rem_nxt   = PW'(avg_r) * PW'(TorqueMax);
        dvs_nxt   = PW'(fs_r) << (TW - 1);
        phase_nxt = P_CHK;
      end
      P_CHK: begin
        // quotient too wide for TW bits clamps anyway
        ovf_nxt   = ({1'b0, rem_r} >= ((PW + 1)'(fs_r) << TW));
        q_nxt     = '0;
        cnt_nxt   = CW'(TW - 1);
        phase_nxt = P_DIV;
      end
      P_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        dvs_nxt = dvs_r >> 1;
        q_nxt   = q_step;
        if (cnt_r == '0) begin
          res_nxt   = (ovf_r || (q_step > TW'(TorqueMax))) ? TW'(TorqueMax) : q_step;
          done_nxt  = 1'b1;
          phase_nxt = P_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
    fs_r  <= fs_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
    ovf_r <= ovf_nxt;
    cnt_r <= cnt_nxt;
  end

  // result to output width
  assign res_ext = {{OW{1'b0}}, res_r};
  assign torque  = res_ext[OW-1:0];
  assign done    = done_r;

endmodule

`default_nettype wire

// File: src/pedal_plausibility_torque_guard_core.sv
// ----------------------------------------------------------------------------
// pedal_plausibility_torque_guard_core
// ready-to-drive sequencing, pedal plausibility checks and torque scaling
// accelerate items that need torque: result loaded when the serial divider,
//   giving one quotient bit a cycle, is done; the next item is taken only
//   after the result is loaded, in the scale or done state
// all other items: result loaded in the eval state, or the done state on stall
// reset: synchronous active low, registers to defaults, not ready, latch clear
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_plausibility_torque_guard_core #(
  parameter int TorqueMax = pptg_pkg::TORQUE_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration port
  input  wire logic                              cfg_we,
  input  wire logic [pptg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pptg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pptg_pkg::SAMPLE_BITS-1:0]  in_throttle_right,
  input  wire logic [pptg_pkg::SAMPLE_BITS-1:0]  in_throttle_left,
  input  wire logic [pptg_pkg::SAMPLE_BITS-1:0]  in_brake_sample,
  input  wire logic                              in_ready_request,
  input  wire logic                              in_ms_tick,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pptg_pkg::TORQUE_W-1:0]          out_torque_command,
  output logic                                   out_drive_ready,
  output logic [pptg_pkg::STATUS_W-1:0]          out_status_code,
  output logic                                   out_fault_flag,
  output logic                                   out_implausible_latched
);

  localparam int SB = pptg_pkg::SAMPLE_BITS;
  localparam int HB = pptg_pkg::HOLD_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_SCALE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [SB-1:0] brake_lvl_r, thr_lvl_r, release_lvl_r, diff_lim_r;
  logic [SB-1:0] disc_lvl_r, upper_lvl_r, full_scale_r;
  logic [HB-1:0] hold_ms_r;

  // sequencing state
  logic          ready_r, hold_r, latch_r;
  logic [HB-1:0] timer_r;

  // captured item
  logic [SB-1:0] it_right_r, it_left_r, it_brake_r;
  logic          it_req_r, it_tick_r;

  // evaluation of the captured item
  logic [SB-1:0]     avg, diff;
  logic [HB-1:0]     timer_inc;
  logic              ev_hold, ev_ready_go, ev_ready_eff, ev_ready, ev_latch, ev_scale;
  logic              ev_fault;
  logic [HB-1:0]     ev_timer;
  pptg_pkg::status_t ev_stat;
  pptg_pkg::status_t stat_r;
  logic              use_scl_r;

  // output side
  logic              out_valid_r;
  logic              out_free, load_out;
  logic [pptg_pkg::TORQUE_W-1:0] torque_sel;
  pptg_pkg::status_t stat_sel;
  logic              ready_sel, latch_sel;
  logic [pptg_pkg::TORQUE_W-1:0] out_torque_r;
  logic              out_ready_r, out_fault_r, out_latch_r;
  pptg_pkg::status_t out_stat_r;

  // scaling unit
  logic                          scl_start, scl_done;
  logic [pptg_pkg::TORQUE_W-1:0] scl_torque;

  // throttle average and sensor disagreement
  assign avg  = SB'((SB + 1)'(it_right_r) + (SB + 1)'(it_left_r) >> 1);
  assign diff = (it_right_r > it_left_r) ? (it_right_r - it_left_r)
                                         : (it_left_r - it_right_r);
  assign timer_inc = (timer_r != {HB{1'b1}}) ? (timer_r + 1'b1) : timer_r;

  // ready hold timing and plausibility checks
  always_comb begin
    ev_hold     = hold_r;
    ev_timer    = timer_r;
    ev_ready_go = 1'b0;
    if (!ready_r) begin
      if (hold_r) begin
        if (!it_req_r) begin
          ev_hold  = 1'b0;
          ev_timer = '0;
        end else if (it_tick_r) begin
          ev_timer = timer_inc;
        end
      end else if (it_req_r && (it_brake_r >= brake_lvl_r)) begin
        ev_hold  = 1'b1;
        ev_timer = '0;
      end
      if (ev_hold && (ev_timer >= hold_ms_r)) begin
        ev_ready_go = 1'b1;
        ev_hold     = 1'b0;
        ev_timer    = '0;
      end
    end
    ev_ready_eff = ready_r | ev_ready_go;

    ev_stat  = pptg_pkg::STAT_WAITING;
    ev_latch = latch_r;
    ev_fault = 1'b0;
    if (ev_ready_eff) begin
      if ((it_right_r > disc_lvl_r) || (it_left_r > disc_lvl_r) ||
          (it_brake_r > disc_lvl_r)) begin
        ev_stat  = pptg_pkg::STAT_DISCONNECT;
        ev_fault = 1'b1;
      end else if (diff > diff_lim_r) begin
        ev_stat  = pptg_pkg::STAT_DISAGREE;
        ev_fault = 1'b1;
      end else if ((it_right_r > upper_lvl_r) || (it_left_r > upper_lvl_r) ||
                   (it_brake_r > upper_lvl_r)) begin
        ev_stat  = pptg_pkg::STAT_RANGE;
        ev_fault = 1'b1;
      end else if (it_brake_r > brake_lvl_r) begin
        if (avg > thr_lvl_r) begin
          ev_latch = 1'b1;
          ev_stat  = pptg_pkg::STAT_BRAKE_THROTTLE;
        end else begin
          ev_stat  = pptg_pkg::STAT_BRAKING;
        end
      end else begin
        ev_stat = pptg_pkg::STAT_ACCEL;
      end
      // latch releases once throttle is back low
      if (ev_latch && (avg < release_lvl_r)) begin
        ev_latch = 1'b0;
      end
    end
    ev_ready = ev_ready_eff & ~ev_fault;
    // torque only for accelerate with the latch clear before this item
    ev_scale = ev_ready_eff && (ev_stat == pptg_pkg::STAT_ACCEL) && !latch_r;
  end

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign scl_start = (state_r == S_EVAL) && ev_scale;
  assign load_out  = out_free && (((state_r == S_EVAL) && !ev_scale) ||
                                  ((state_r == S_SCALE) && scl_done) ||
                                  (state_r == S_DONE));

  // result selection
  always_comb begin
    if (state_r == S_EVAL) begin
      stat_sel  = ev_stat;
      ready_sel = ev_ready;
      latch_sel = ev_latch;
    end else begin
      stat_sel  = stat_r;
      ready_sel = ready_r;
      latch_sel = latch_r;
    end
    if ((state_r == S_SCALE) || ((state_r == S_DONE) && use_scl_r)) begin
      torque_sel = scl_torque;
    end else begin
      torque_sel = '0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (ev_scale) begin
          state_nxt = S_SCALE;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCALE: begin
        if (scl_done) begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ready_r       <= 1'b0;
      hold_r        <= 1'b0;
      timer_r       <= '0;
      latch_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      brake_lvl_r   <= pptg_pkg::BRAKE_ACTIVE_RST;
      thr_lvl_r     <= pptg_pkg::THROTTLE_ACTIVE_RST;
      release_lvl_r <= pptg_pkg::RELEASE_RST;
      diff_lim_r    <= pptg_pkg::DIFF_LIMIT_RST;
      disc_lvl_r    <= pptg_pkg::DISCONNECT_RST;
      upper_lvl_r   <= pptg_pkg::UPPER_VALID_RST;
      full_scale_r  <= pptg_pkg::FULL_SCALE_RST;
      hold_ms_r     <= pptg_pkg::READY_HOLD_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EVAL) begin
        ready_r <= ev_ready;
        hold_r  <= ev_hold;
        timer_r <= ev_timer;
        latch_r <= ev_latch;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_we) begin
        case (pptg_pkg::cfg_index_t'(cfg_index))
          pptg_pkg::REG_BRAKE_ACTIVE:    brake_lvl_r   <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_THROTTLE_ACTIVE: thr_lvl_r     <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_RELEASE:         release_lvl_r <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_DIFF_LIMIT:      diff_lim_r    <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_DISCONNECT:      disc_lvl_r    <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_UPPER_VALID:     upper_lvl_r   <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_FULL_SCALE:      full_scale_r  <= cfg_wdata[SB-1:0];
          pptg_pkg::REG_READY_HOLD:      hold_ms_r     <= cfg_wdata[HB-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      it_right_r <= in_throttle_right;
      it_left_r  <= in_throttle_left;
      it_brake_r <= in_brake_sample;
      it_req_r   <= in_ready_request;
      it_tick_r  <= in_ms_tick;
    end
    if (state_r == S_EVAL) begin
      stat_r    <= ev_stat;
      use_scl_r <= ev_scale;
    end
    if (load_out) begin
      out_torque_r <= torque_sel;
      out_ready_r  <= ready_sel;
      out_stat_r   <= stat_sel;
      out_fault_r  <= (stat_sel == pptg_pkg::STAT_DISCONNECT) ||
                      (stat_sel == pptg_pkg::STAT_DISAGREE) ||
                      (stat_sel == pptg_pkg::STAT_RANGE);
      out_latch_r  <= latch_sel;
    end
  end

  // multiply and serial divide unit
  pptg_scale #(
    .TorqueMax (TorqueMax)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scl_start),
    .avg        (avg),
    .full_scale (full_scale_r),
    .done       (scl_done),
    .torque     (scl_torque)
  );

  assign out_valid               = out_valid_r;
  assign out_torque_command      = out_torque_r;
  assign out_drive_ready         = out_ready_r;
  assign out_status_code         = out_stat_r;
  assign out_fault_flag          = out_fault_r;
  assign out_implausible_latched = out_latch_r;

endmodule

`default_nettype wire

// File: src/pptg_checker.sv
// ----------------------------------------------------------------------------
// pptg_checker
// port-level checks on the result items of the torque guard, bound to the
// top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pptg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [pptg_pkg::TORQUE_W-1:0]     out_torque_command,
  input wire logic                              out_drive_ready,
  input wire logic [pptg_pkg::STATUS_W-1:0]     out_status_code,
  input wire logic                              out_fault_flag
);

  logic is_fault_code;
  logic is_accel;
  logic is_waiting;
  logic torque_zero;

  // decoded result fields
  assign is_fault_code = (out_status_code == pptg_pkg::STAT_DISCONNECT) ||
                         (out_status_code == pptg_pkg::STAT_DISAGREE) ||
                         (out_status_code == pptg_pkg::STAT_RANGE);
  assign is_accel      = (out_status_code == pptg_pkg::STAT_ACCEL);
  assign is_waiting    = (out_status_code == pptg_pkg::STAT_WAITING);
  assign torque_zero   = (out_torque_command == '0);

  // torque only ever comes with an accelerate item
  `PPTG_ASSERT_IMP(a_torque_only_accel, out_valid && !torque_zero, is_accel)

  // fault flag follows the fault status codes
  `PPTG_ASSERT_IMP(a_fault_matches_status, out_valid, out_fault_flag == is_fault_code)

  // a fault always drops the drive state
  `PPTG_ASSERT_IMP(a_fault_not_ready, out_valid && out_fault_flag, !out_drive_ready)

  // a waiting item never reports drive state or torque
  `PPTG_ASSERT_IMP(a_waiting_idle, out_valid && is_waiting, !out_drive_ready && torque_zero)

  // a stalled item stays offered
  `PPTG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind pedal_plausibility_torque_guard_core pptg_checker u_pptg_checker (.*);

`default_nettype wire
